@@ design/opt_pkg.sv @@
// Package for the obstacle persistence table: register indexes, operation codes
// and the command record that passes from the front end to the back end.
`timescale 1ns / 1ps
package opt_pkg;
    localparam int RADIUS_WIDTH = 15;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_X_TOL = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_TOL = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Z_TOL = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_R_TOL = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_R = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAMES = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_SIGHT = 3'd6;
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef enum logic [1:0] {
        CMD_POINT_MATCH,
        CMD_POINT_APPEND,
        CMD_PUBLISH
    } t_cmd_kind;
endpackage

@@ design/opt_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
// Depends on opt_pkg for the radius, register index and data widths.
`timescale 1ns / 1ps
interface opt_in_if #(parameter int COORD_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [COORD_WIDTH-1:0]            pos_x;
    logic [COORD_WIDTH-1:0]            pos_y;
    logic [COORD_WIDTH-1:0]            pos_z;
    logic [opt_pkg::RADIUS_WIDTH-1:0]  radius;
    modport source (output valid, operation, pos_x, pos_y, pos_z, radius, input ready);
    modport sink (input valid, operation, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface opt_out_if #(parameter int COORD_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic [COORD_WIDTH-1:0]            obstacle_x;
    logic [COORD_WIDTH-1:0]            obstacle_y;
    logic [COORD_WIDTH-1:0]            obstacle_z;
    logic [opt_pkg::RADIUS_WIDTH-1:0]  obstacle_radius;
    logic                              list_empty;
    logic                              last_of_list;
    logic [15:0]                       dropped_points;
    modport source (output valid, obstacle_x, obstacle_y, obstacle_z, obstacle_radius,
                    list_empty, last_of_list, dropped_points, input ready);
    modport sink (input valid, obstacle_x, obstacle_y, obstacle_z, obstacle_radius,
                  list_empty, last_of_list, dropped_points, output ready);
endinterface

interface opt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [opt_pkg::CFG_IDX_WIDTH-1:0]   index;
    logic [opt_pkg::CFG_DATA_WIDTH-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/opt_front.sv @@
// Front end: accepts items, tracks frames and turns the items it keeps into commands.
// Depends on opt_pkg; the back end reports the table fill through i_entry_count.
`timescale 1ns / 1ps
module opt_front #(
    parameter int CNT_WIDTH = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [14:0]                   i_radius,
    input  logic [14:0]                   i_max_radius,
    input  logic [7:0]                    i_frames_per_publish,
    input  logic [CNT_WIDTH-1:0]          i_entry_count,
    input  logic                          i_back_idle,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output opt_pkg::t_cmd_kind            o_cmd_kind
);
    import opt_pkg::*;

    logic [7:0] r_frames_seen, n_frames_seen;
    logic       r_ignore_frame;
    logic       r_started_empty;
    logic       w_accept;
    logic       w_take;

    assign n_frames_seen = r_frames_seen + 8'd1;
    // Frame starts read the fill count, so they wait until the back end is done.
    assign o_ready = i_cmd_ready && (i_operation == OP_POINT || i_back_idle);
    assign w_accept = i_valid && o_ready;
    assign w_take = (i_operation == OP_FRAME) ? (n_frames_seen == i_frames_per_publish)
                  : (!r_ignore_frame && i_radius < i_max_radius);
    assign o_cmd_valid = w_accept && w_take;

    always_comb begin
        if (i_operation == OP_FRAME) begin
            o_cmd_kind = CMD_PUBLISH;
        end else if (r_started_empty) begin
            o_cmd_kind = CMD_POINT_APPEND;
        end else begin
            o_cmd_kind = CMD_POINT_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_seen   <= '0;
            r_ignore_frame  <= 1'b0;
            r_started_empty <= 1'b1;
        end else if (w_accept && i_operation == OP_FRAME) begin
            if (n_frames_seen == i_frames_per_publish) begin
                r_frames_seen  <= '0;
                r_ignore_frame <= 1'b1;
            end else begin
                r_frames_seen   <= n_frames_seen;
                r_ignore_frame  <= 1'b0;
                r_started_empty <= (i_entry_count == '0);
            end
        end
    end
endmodule

@@ design/opt_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on nothing; the payload width is a parameter.
`timescale 1ns / 1ps
module opt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != DEPTH[PW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{PW{1'b0}}, w_push} - {{PW{1'b0}}, w_pop};
        end
    end
endmodule

@@ design/opt_back.sv @@
// Back end: holds the table, appends points and walks it entry by entry to match or publish.
// Depends on opt_pkg for the command codes.
`timescale 1ns / 1ps
module opt_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_WIDTH = 16,
    parameter int WEIGHT_WIDTH = 16,
    parameter int CNT_WIDTH = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  opt_pkg::t_cmd_kind            i_cmd_kind,
    input  logic [COORD_WIDTH-1:0]        i_px,
    input  logic [COORD_WIDTH-1:0]        i_py,
    input  logic [COORD_WIDTH-1:0]        i_pz,
    input  logic [14:0]                   i_pr,
    input  logic [14:0]                   i_x_tol,
    input  logic [14:0]                   i_y_tol,
    input  logic [14:0]                   i_z_tol,
    input  logic [14:0]                   i_r_tol,
    input  logic [15:0]                   i_min_sightings,
    output logic [CNT_WIDTH-1:0]          o_entry_count,
    output logic                          o_idle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_WIDTH-1:0]        o_x,
    output logic [COORD_WIDTH-1:0]        o_y,
    output logic [COORD_WIDTH-1:0]        o_z,
    output logic [14:0]                   o_r,
    output logic                          o_list_empty,
    output logic                          o_last,
    output logic [15:0]                   o_dropped
);
    import opt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = 3 * COORD_WIDTH + 15;
    localparam int NW = ((COORD_WIDTH > 15) ? COORD_WIDTH : 15) + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_APPEND, S_EMIT, S_HOLD
    } t_state;

    logic [EW-1:0]           r_mem_e [TABLE_DEPTH];
    logic [WEIGHT_WIDTH-1:0] r_mem_w [TABLE_DEPTH];
    t_state                  r_state;
    t_cmd_kind               r_kind;
    logic [CNT_WIDTH-1:0]    r_count, r_idx;
    logic [15:0]             r_drops;
    logic                    r_found, r_any;
    logic [COORD_WIDTH-1:0]  r_px, r_py, r_pz;
    logic [14:0]             r_pr;
    logic [COORD_WIDTH-1:0]  r_pend_x, r_pend_y, r_pend_z;
    logic [14:0]             r_pend_r;
    logic [EW-1:0]           r_rd_e;
    logic [WEIGHT_WIDTH-1:0] r_rd_w;
    logic [COORD_WIDTH-1:0]  w_ex, w_ey, w_ez;
    logic [14:0]             w_er;
    logic                    w_match, w_qual, w_lastidx;
    logic                    w_wr_w;
    logic [WEIGHT_WIDTH-1:0] w_inc;

    function automatic logic near(input logic signed [NW-1:0] a,
                                  input logic signed [NW-1:0] b,
                                  input logic [14:0] tol);
        logic signed [NW-1:0] d;
        d = a - b;
        if (d < 0) begin
            d = -d;
        end
        return d < $signed({{(NW - 15){1'b0}}, tol});
    endfunction

    assign {w_ex, w_ey, w_ez, w_er} = r_rd_e;
    assign w_match = near(NW'($signed(w_ex)), NW'($signed(r_px)), i_x_tol)
                  && near(NW'($signed(w_ey)), NW'($signed(r_py)), i_y_tol)
                  && near(NW'($signed(w_ez)), NW'($signed(r_pz)), i_z_tol)
                  && near(NW'(w_er), NW'(r_pr), i_r_tol);
    assign w_qual = {{(32 - WEIGHT_WIDTH){1'b0}}, r_rd_w} >= {16'd0, i_min_sightings};
    assign w_lastidx = (r_idx + 1'b1 >= r_count);
    assign w_inc = (&r_rd_w) ? r_rd_w : r_rd_w + 1'b1;
    assign w_wr_w = (r_state == S_CHECK) && (r_kind == CMD_POINT_MATCH) && w_match;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_idle = (r_state == S_IDLE) && !i_cmd_valid;
    assign o_entry_count = r_count;

    always_ff @(posedge i_clk) begin
        r_rd_e <= r_mem_e[r_idx[AW-1:0]];
        r_rd_w <= r_mem_w[r_idx[AW-1:0]];
        if (w_wr_w) begin
            r_mem_w[r_idx[AW-1:0]] <= w_inc;
        end
        if (r_state == S_APPEND && r_count != TABLE_DEPTH[CNT_WIDTH-1:0]) begin
            r_mem_e[r_count[AW-1:0]] <= {r_px, r_py, r_pz, r_pr};
            r_mem_w[r_count[AW-1:0]] <= {{(WEIGHT_WIDTH - 1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drops <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_any   <= 1'b0;
            o_valid <= 1'b0;
            r_kind  <= CMD_POINT_MATCH;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_kind  <= i_cmd_kind;
                        r_px    <= i_px;
                        r_py    <= i_py;
                        r_pz    <= i_pz;
                        r_pr    <= i_pr;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_any   <= 1'b0;
                        if (i_cmd_kind == CMD_POINT_APPEND) begin
                            r_state <= S_APPEND;
                        end else if (r_count == '0) begin
                            r_state <= (i_cmd_kind == CMD_PUBLISH) ? S_EMIT : S_APPEND;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_kind == CMD_PUBLISH) begin
                        // A qualifying entry waits until the next one shows up, so the
                        // final one of the list can carry the last flag.
                        if (w_qual) begin
                            r_pend_x <= w_ex;
                            r_pend_y <= w_ey;
                            r_pend_z <= w_ez;
                            r_pend_r <= w_er;
                            r_any    <= 1'b1;
                        end
                        if (w_qual && r_any) begin
                            o_x          <= r_pend_x;
                            o_y          <= r_pend_y;
                            o_z          <= r_pend_z;
                            o_r          <= r_pend_r;
                            o_list_empty <= 1'b0;
                            o_last       <= 1'b0;
                            o_dropped    <= r_drops;
                            o_valid      <= 1'b1;
                            r_state      <= S_HOLD;
                        end else if (!w_lastidx) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        if (w_match) begin
                            r_found <= 1'b1;
                        end
                        if (!w_lastidx) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_state <= (r_found || w_match) ? S_IDLE : S_APPEND;
                        end
                    end
                end
                S_HOLD: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (!w_lastidx) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    // The final transaction: the held entry, or an empty marker.
                    if (!o_valid) begin
                        o_x          <= r_any ? r_pend_x : '0;
                        o_y          <= r_any ? r_pend_y : '0;
                        o_z          <= r_any ? r_pend_z : '0;
                        o_r          <= r_any ? r_pend_r : '0;
                        o_list_empty <= !r_any;
                        o_last       <= 1'b1;
                        o_dropped    <= r_drops;
                        o_valid      <= 1'b1;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_APPEND: begin
                    if (r_count != TABLE_DEPTH[CNT_WIDTH-1:0]) begin
                        r_count <= r_count + 1'b1;
                    end else if (r_drops != 16'hFFFF) begin
                        r_drops <= r_drops + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= TABLE_DEPTH[CNT_WIDTH-1:0];
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("table fill overflow");

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x) && $stable(o_last))
        else $error("result changed while stalled");

    a_no_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_cmd_ready) else $error("command taken while publishing");
endmodule

@@ design/obstacle_persistence_table.sv @@
// Top level of the obstacle persistence table: configuration registers,
// front end, command queue and back end. Depends on opt_pkg and opt_if.
//
// Channels: in_if takes points (operation 0) and frame starts (operation 1);
// out_if returns published obstacle entries; cfg_if writes the seven registers.
// In the back end a point reads, then compares, each stored entry in turn; a
// point whose frame began with an empty table is appended without a scan. The
// front end drops filtered points, so they never reach the back end. Points
// queue ahead of the back end in a two-deep queue.
// A frame start waits until the back end is idle, since it samples the fill.
// A publishing frame start walks the table entry by entry and emits one
// transaction per qualifying entry, the final one with last_of_list set; when
// nothing qualifies it emits a single transaction with list_empty and
// last_of_list set and zero position fields. Each qualifying entry is held
// until the next one is found, so the flag lands on the true final entry.
// While the receiver stalls the back end holds.
// Reset clears the fill count, frame counter and drop counter; entries
// are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module obstacle_persistence_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_WIDTH = 16,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    opt_in_if.sink      in_if,
    opt_out_if.source   out_if,
    opt_cfg_if.sink     cfg_if
);
    import opt_pkg::*;
    localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);
    localparam int QW = 2 + 3 * COORD_WIDTH + 15;

    logic [14:0] r_x_tol, r_y_tol, r_z_tol, r_r_tol, r_max_r;
    logic [7:0]  r_frames;
    logic [15:0] r_min_sight;

    assign cfg_if.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_tol     <= 15'd205;
            r_y_tol     <= 15'd205;
            r_z_tol     <= 15'd205;
            r_r_tol     <= 15'd205;
            r_max_r     <= 15'd512;
            r_frames    <= 8'd1;
            r_min_sight <= 16'd1;
        end else if (cfg_if.valid) begin
            unique case (cfg_if.index)
                REG_X_TOL:     r_x_tol     <= cfg_if.data[14:0];
                REG_Y_TOL:     r_y_tol     <= cfg_if.data[14:0];
                REG_Z_TOL:     r_z_tol     <= cfg_if.data[14:0];
                REG_R_TOL:     r_r_tol     <= cfg_if.data[14:0];
                REG_MAX_R:     r_max_r     <= cfg_if.data[14:0];
                REG_FRAMES:    r_frames    <= cfg_if.data[7:0];
                REG_MIN_SIGHT: r_min_sight <= cfg_if.data;
                default: ;
            endcase
        end
    end

    logic                 w_cmd_valid, w_q_ready, w_q_valid, w_b_ready, w_idle;
    t_cmd_kind            w_kind, w_q_kind;
    logic [CNT_WIDTH-1:0] w_count;
    logic [QW-1:0]        w_q_out;
    logic [COORD_WIDTH-1:0] w_qx, w_qy, w_qz;
    logic [14:0]          w_qr;
    logic [1:0]           w_qk;

    opt_front #(.CNT_WIDTH(CNT_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_if.valid), .o_ready(in_if.ready), .i_operation(in_if.operation),
        .i_radius(in_if.radius), .i_max_radius(r_max_r), .i_frames_per_publish(r_frames),
        .i_entry_count(w_count), .i_back_idle(w_idle && !w_q_valid),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_q_ready), .o_cmd_kind(w_kind)
    );

    opt_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_cmd_valid), .o_ready(w_q_ready),
        .i_data({w_kind, in_if.pos_x, in_if.pos_y, in_if.pos_z, in_if.radius}),
        .o_valid(w_q_valid), .i_ready(w_b_ready), .o_data(w_q_out)
    );

    assign {w_qk, w_qx, w_qy, w_qz, w_qr} = w_q_out;
    assign w_q_kind = t_cmd_kind'(w_qk);

    opt_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_WIDTH(COORD_WIDTH),
               .WEIGHT_WIDTH(WEIGHT_WIDTH), .CNT_WIDTH(CNT_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_q_valid), .o_cmd_ready(w_b_ready), .i_cmd_kind(w_q_kind),
        .i_px(w_qx), .i_py(w_qy), .i_pz(w_qz), .i_pr(w_qr),
        .i_x_tol(r_x_tol), .i_y_tol(r_y_tol), .i_z_tol(r_z_tol), .i_r_tol(r_r_tol),
        .i_min_sightings(r_min_sight), .o_entry_count(w_count), .o_idle(w_idle),
        .o_valid(out_if.valid), .i_ready(out_if.ready),
        .o_x(out_if.obstacle_x), .o_y(out_if.obstacle_y), .o_z(out_if.obstacle_z),
        .o_r(out_if.obstacle_radius), .o_list_empty(out_if.list_empty),
        .o_last(out_if.last_of_list), .o_dropped(out_if.dropped_points)
    );
endmodule

@@ tb/tb_obstacle_persistence_table.sv @@
// Self-checking testbench for obstacle_persistence_table: a directed table and random frames
// are checked against a local predictor of the persistence table. Depends on opt_pkg, opt_if.
`timescale 1ns / 1ps
module tb_obstacle_persistence_table;
    import opt_pkg::*;

    typedef struct packed {
        logic        op;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [14:0] r;
    } t_point;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [14:0] r;
        logic        empty;
        logic        last;
        logic [15:0] drops;
    } t_obstacle;

    typedef enum int {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        t_point      pt;
        bit          typed;
        t_obstacle   typed_res;
    } t_row;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    opt_in_if #(.COORD_WIDTH(16)) in_ch();
    opt_out_if #(.COORD_WIDTH(16)) out_ch();
    opt_cfg_if cfg_ch();

    obstacle_persistence_table u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_if(in_ch),
        .out_if(out_ch),
        .cfg_if(cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state.
    logic [14:0] tol_x, tol_y, tol_z, tol_r, max_r;
    logic [7:0]  publish_frames;
    logic [15:0] weight_floor;
    logic signed [15:0] tab_x [DEPTH];
    logic signed [15:0] tab_y [DEPTH];
    logic signed [15:0] tab_z [DEPTH];
    logic [14:0] tab_r [DEPTH];
    logic [15:0] tab_w [DEPTH];
    int          tab_fill;
    logic [7:0]  frame_cnt;
    bit          skip_frame;
    bit          frame_began_empty;
    logic [15:0] drop_cnt;

    t_obstacle pending_obstacles[$];
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  hold_left;
    int  quiet_cycles;
    logic signed [15:0] centers [6][3];
    logic [14:0] center_r [6];

    function automatic bit within_tol(logic signed [15:0] a, logic signed [15:0] b,
                                      logic [14:0] tol);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d < int'(tol);
    endfunction

    task automatic predict_table(input t_point pt, ref t_obstacle res[$]);
        t_obstacle o;
        bit hit;
        res.delete();
        if (pt.op == OP_FRAME) begin
            frame_cnt = frame_cnt + 8'd1;
            if (frame_cnt == publish_frames) begin
                frame_cnt = 8'd0;
                skip_frame = 1'b1;
                for (int i = 0; i < tab_fill; i++) begin
                    if (tab_w[i] >= weight_floor) begin
                        o = '{tab_x[i], tab_y[i], tab_z[i], tab_r[i], 1'b0, 1'b0, drop_cnt};
                        res.insert(res.size(), o);
                    end
                end
                if (res.size() == 0) begin
                    o = '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b0, drop_cnt};
                    res.insert(res.size(), o);
                end
                res[res.size()-1].last = 1'b1;
            end else begin
                skip_frame = 1'b0;
                frame_began_empty = (tab_fill == 0);
            end
            return;
        end
        if (skip_frame || pt.r >= max_r) return;
        hit = 1'b0;
        if (!frame_began_empty) begin
            for (int i = 0; i < tab_fill; i++) begin
                if (within_tol(tab_x[i], pt.x, tol_x) && within_tol(tab_y[i], pt.y, tol_y) &&
                    within_tol(tab_z[i], pt.z, tol_z) &&
                    within_tol($signed({1'b0, tab_r[i]}), $signed({1'b0, pt.r}), tol_r)) begin
                    if (tab_w[i] != 16'hFFFF) tab_w[i] = tab_w[i] + 16'd1;
                    hit = 1'b1;
                end
            end
        end
        if (!hit) begin
            if (tab_fill >= DEPTH) begin
                if (drop_cnt != 16'hFFFF) drop_cnt = drop_cnt + 16'd1;
            end else begin
                tab_x[tab_fill] = pt.x;
                tab_y[tab_fill] = pt.y;
                tab_z[tab_fill] = pt.z;
                tab_r[tab_fill] = pt.r;
                tab_w[tab_fill] = 16'd1;
                tab_fill++;
            end
        end
    endtask

    task automatic send_point(input t_point pt, input bit typed, input t_obstacle typed_res);
        t_obstacle res[$];
        in_ch.valid <= 1'b1;
        in_ch.operation <= pt.op;
        in_ch.pos_x <= pt.x;
        in_ch.pos_y <= pt.y;
        in_ch.pos_z <= pt.z;
        in_ch.radius <= pt.r;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_table(pt, res);
        if (typed) res = '{typed_res};
        foreach (res[i]) pending_obstacles.insert(pending_obstacles.size(), res[i]);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_obstacles.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_X_TOL:     tol_x = val[14:0];
            REG_Y_TOL:     tol_y = val[14:0];
            REG_Z_TOL:     tol_z = val[14:0];
            REG_R_TOL:     tol_r = val[14:0];
            REG_MAX_R:     max_r = val[14:0];
            REG_FRAMES:    publish_frames = val[7:0];
            REG_MIN_SIGHT: weight_floor = val;
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [15:0] tol, input logic [15:0] maxr,
                               input logic [15:0] frames, input logic [15:0] minw);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_X_TOL, tol);
        write_reg(REG_Y_TOL, tol ^ 16'h0001);
        write_reg(REG_Z_TOL, tol);
        write_reg(REG_R_TOL, tol);
        write_reg(REG_MAX_R, maxr);
        write_reg(REG_FRAMES, frames);
        write_reg(REG_MIN_SIGHT, minw);
        for (int c = 0; c < 6; c++) begin
            for (int a = 0; a < 3; a++) centers[c][a] = 16'($urandom());
            center_r[c] = 15'($urandom_range(0, (max_r > 0) ? max_r - 1 : 0));
        end
    endtask

    function automatic t_point random_point(int frame_pct);
        t_point pt;
        int c;
        pt.op = ($urandom_range(99) < frame_pct) ? OP_FRAME : OP_POINT;
        if ($urandom_range(99) < 75) begin
            c = $urandom_range(0, 5);
            pt.x = centers[c][0] + 16'($urandom_range(0, 400)) - 16'd200;
            pt.y = centers[c][1] + 16'($urandom_range(0, 400)) - 16'd200;
            pt.z = centers[c][2] + 16'($urandom_range(0, 400)) - 16'd200;
            pt.r = center_r[c] + 15'($urandom_range(0, 40)) - 15'd20;
        end else begin
            pt.x = 16'($urandom());
            pt.y = 16'($urandom());
            pt.z = 16'($urandom());
            pt.r = 15'($urandom_range(0, 32767));
        end
        return pt;
    endfunction

    task automatic random_phase(int n_items, int frame_pct);
        for (int k = 0; k < n_items; k++) send_point(random_point(frame_pct), 1'b0, '0);
    endtask

    function automatic t_row item_row(logic op, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] z, logic [14:0] r);
        t_row row;
        row = '{ROW_ITEM, REG_X_TOL, 16'd0, '{op, x, y, z, r}, 1'b0, '0};
        return row;
    endfunction

    function automatic t_row cfg_row(logic [2:0] idx, logic [15:0] val);
        t_row row;
        row = '{ROW_CFG, idx, val, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_row empty_list_row();
        t_row row;
        row = item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0);
        row.typed = 1'b1;
        row.typed_res = '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b1, 16'd0};
        return row;
    endfunction

    // Receiver: random back-pressure, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_request && hold_left == 0) begin
            hold_request <= 1'b0;
            hold_left <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_obstacle want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_obstacles.size() == 0) begin
                $error("unexpected obstacle transaction x=%0d", $signed(out_ch.obstacle_x));
                errors++;
            end else begin
                want = pending_obstacles.pop_front();
                if (out_ch.obstacle_x !== want.x) begin
                    $error("obstacle_x expected %0d actual %0d", $signed(want.x),
                           $signed(out_ch.obstacle_x));
                    errors++;
                end
                if (out_ch.obstacle_y !== want.y) begin
                    $error("obstacle_y expected %0d actual %0d", $signed(want.y),
                           $signed(out_ch.obstacle_y));
                    errors++;
                end
                if (out_ch.obstacle_z !== want.z) begin
                    $error("obstacle_z expected %0d actual %0d", $signed(want.z),
                           $signed(out_ch.obstacle_z));
                    errors++;
                end
                if (out_ch.obstacle_radius !== want.r) begin
                    $error("obstacle_radius expected %0d actual %0d", want.r,
                           out_ch.obstacle_radius);
                    errors++;
                end
                if (out_ch.list_empty !== want.empty) begin
                    $error("list_empty expected %0d actual %0d", want.empty, out_ch.list_empty);
                    errors++;
                end
                if (out_ch.last_of_list !== want.last) begin
                    $error("last_of_list expected %0d actual %0d", want.last,
                           out_ch.last_of_list);
                    errors++;
                end
                if (out_ch.dropped_points !== want.drops) begin
                    $error("dropped_points expected %0d actual %0d", want.drops,
                           out_ch.dropped_points);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row rows[$];
        errors = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_POINT;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.radius = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_X_TOL;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        tol_x = 15'd205;
        tol_y = 15'd205;
        tol_z = 15'd205;
        tol_r = 15'd205;
        max_r = 15'd512;
        publish_frames = 8'd1;
        weight_floor = 16'd1;
        tab_fill = 0;
        frame_cnt = 8'd0;
        skip_frame = 1'b0;
        frame_began_empty = 1'b1;
        drop_cnt = 16'd0;
        for (int c = 0; c < 6; c++) begin
            for (int a = 0; a < 3; a++) centers[c][a] = 16'($urandom());
            center_r[c] = 15'($urandom_range(0, 511));
        end

        rows.insert(rows.size(), empty_list_row());
        rows.insert(rows.size(), cfg_row(REG_FRAMES, 16'd3));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd100, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_POINT, 16'h7FFF, 16'h8000, 16'h8000, 15'd511));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd5, 16'd5, 16'd5, 15'd512));
        rows.insert(rows.size(), item_row(OP_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd204, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd205, 16'd204, 16'hFF34, 15'd204));
        rows.insert(rows.size(), item_row(OP_POINT, 16'h8000, 16'h7FFF, 16'h7FFF, 15'd0));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_POINT, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), cfg_row(REG_MIN_SIGHT, 16'd2));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), cfg_row(REG_MIN_SIGHT, 16'hFFFF));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), item_row(OP_FRAME, 16'd0, 16'd0, 16'd0, 15'd0));
        rows.insert(rows.size(), empty_list_row());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_all_results();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_point(rows[i].pt, rows[i].typed, rows[i].typed_res);
            end
        end

        send_idle_pct = 13;
        recv_idle_pct = 76;
        reconfigure(16'd205, 16'd512, 16'd2, 16'd1);
        hold_request = 1'b1;
        random_phase(40, 15);
        reconfigure(16'd0, 16'h7FFF, 16'd3, 16'd1);
        random_phase(15, 8);
        wait_all_results();
        random_phase(15, 8);

        send_idle_pct = 76;
        recv_idle_pct = 13;
        reconfigure(16'h7FFF, 16'h7FFF, 16'd4, 16'd3);
        random_phase(30, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reconfigure(16'd1000, 16'd0, 16'd1, 16'd0);
        random_phase(15, 30);
        reconfigure(16'd300, 16'd16384, 16'd50, 16'd2);
        random_phase(65, 90);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
